// ----- src/vwpbp_pkg.sv -----
// shared types and constants of the pair bit packer
`timescale 1ns / 1ps

package vwpbp_pkg;

   localparam int MAX_CODE_BITS = 16;
   localparam int CODE_FIELD_BITS = 16;
   localparam int BITS_PER_BYTE = 8;
   localparam int PEND_BITS = BITS_PER_BYTE - 1;
   localparam int CNT_BITS = 3;
   localparam int ACC_BITS = 31;
   localparam int MAX_BYTES = 3;
   localparam int NBYTE_BITS = 2;

   // effective code width ceiling: the smaller of the limit and the field width
   localparam int WIDTH_LIMIT_INT =
      (MAX_CODE_BITS < CODE_FIELD_BITS) ? MAX_CODE_BITS : CODE_FIELD_BITS;
   localparam logic [4:0] WIDTH_LIMIT = 5'(WIDTH_LIMIT_INT);

   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [15:0] code;
      logic [4:0]  code_width;
      logic [7:0]  symbol;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } rsp_payload_type;

   // bytes completed by one request, earliest byte in the low bits
   typedef struct packed {
      logic [MAX_BYTES*BITS_PER_BYTE-1:0] data;
      logic [NBYTE_BITS-1:0]              count;
   } pack_result_type;

endpackage

// ----- src/vwpbp_pack.sv -----
// bit accumulator: merges one request into the pending bits
`timescale 1ns / 1ps

module vwpbp_pack (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  vwpbp_pkg::req_payload_type item,
   output vwpbp_pkg::pack_result_type result
);
   import vwpbp_pkg::*;

   logic [PEND_BITS-1:0] pend_bits_ff, pend_bits_in;
   logic [CNT_BITS-1:0]  pend_cnt_ff, pend_cnt_in;

   logic [4:0]          width;
   logic [15:0]         mask;
   logic [15:0]         code_masked;
   logic [4:0]          sym_pos;
   logic [4:0]          total;
   logic [ACC_BITS-1:0] acc;

   always_comb begin
      width = (item.code_width > WIDTH_LIMIT) ? WIDTH_LIMIT : item.code_width;
      mask = ~({16{1'b1}} << width);
      code_masked = item.code & mask;
      sym_pos = 5'(pend_cnt_ff) + width;
      total = sym_pos + 5'(BITS_PER_BYTE);
      acc = {{(ACC_BITS-PEND_BITS){1'b0}}, pend_bits_ff}
          | ({{(ACC_BITS-16){1'b0}}, code_masked} << pend_cnt_ff)
          | ({{(ACC_BITS-8){1'b0}}, item.symbol} << sym_pos);
   end

   always_comb begin
      result.data = '0;
      result.count = '0;
      pend_bits_in = '0;
      pend_cnt_in = '0;
      if (item.operation == OP_FLUSH) begin
         // padded partial byte, only when bits are waiting
         result.data = {{(MAX_BYTES*BITS_PER_BYTE-PEND_BITS){1'b0}}, pend_bits_ff};
         result.count = (pend_cnt_ff != '0) ? NBYTE_BITS'(1) : '0;
      end else begin
         result.data = acc[MAX_BYTES*BITS_PER_BYTE-1:0];
         result.count = total[4:3];
         pend_cnt_in = total[2:0];
         unique case (total[4:3])
            2'd1:    pend_bits_in = acc[14:8];
            2'd2:    pend_bits_in = acc[22:16];
            2'd3:    pend_bits_in = acc[30:24];
            default: pend_bits_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bits_ff <= '0;
         pend_cnt_ff <= '0;
      end else if (load) begin
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff <= pend_cnt_in;
      end
   end

endmodule

// ----- src/vwpbp_drain.sv -----
// result register: hands out the completed bytes one per cycle while rsp_stall is low
`timescale 1ns / 1ps

module vwpbp_drain (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  vwpbp_pkg::pack_result_type result,
   output logic                       free,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output vwpbp_pkg::rsp_payload_type rsp_payload
);
   import vwpbp_pkg::*;

   logic [MAX_BYTES*BITS_PER_BYTE-1:0] data_ff;
   logic [NBYTE_BITS-1:0]              left_ff;
   logic                               take;

   assign rsp_valid = (left_ff != '0);
   assign take = rsp_valid && !rsp_stall;
   // free now, or free once the last byte goes this cycle
   assign free = (left_ff == '0) || (left_ff == NBYTE_BITS'(1) && take);
   assign rsp_payload.out_byte = data_ff[BITS_PER_BYTE-1:0];
   assign rsp_payload.last_byte = (left_ff == NBYTE_BITS'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else if (load) begin
         left_ff <= result.count;
      end else if (take) begin
         left_ff <= left_ff - NBYTE_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result.data;
      end else if (take) begin
         data_ff <= data_ff >> BITS_PER_BYTE;
      end
   end

endmodule

// ----- src/variable_width_pair_bit_packer_core.sv -----
// top level of the lsb-first pair bit packer
//
//   channel  direction  carries
//   req_     in         append pair (code, width, symbol) or flush request
//   rsp_     out        one packed byte with an end-of-request marker
//
// a request waits in the input register until the result register is free,
// then merges into the result register, which sends one byte per cycle
// while rsp_ is not stalled: an append yields one to three bytes, a flush
// one byte or none; the result register's byte-per-cycle output sets the rate
// synchronous active-high reset empties both registers and the pending bits
// a stall on rsp_ holds the byte; req_stall rises once the input register
// is full and the result register holds more than a last byte leaving now
`timescale 1ns / 1ps

module variable_width_pair_bit_packer_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  vwpbp_pkg::req_payload_type req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output vwpbp_pkg::rsp_payload_type rsp_payload
);
   import vwpbp_pkg::*;

   // input register
   logic            in_valid_ff;
   req_payload_type in_item_ff;

   logic            free;
   logic            move;
   pack_result_type result;

   // request moves into the result register as soon as it has room
   assign move = in_valid_ff && free;
   assign req_stall = in_valid_ff && !free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (move) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_payload;
      end
   end

   // merge with the pending bits, pending state advances on the move
   vwpbp_pack u_pack (
      .clock  (clock),
      .reset  (reset),
      .load   (move),
      .item   (in_item_ff),
      .result (result)
   );

   // completed bytes leave one per cycle while rsp_stall is low
   vwpbp_drain u_drain (
      .clock       (clock),
      .reset       (reset),
      .load        (move),
      .result      (result),
      .free        (free),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- src/vwpbp_checker.sv -----
// port checks of the pair bit packer and their binding
`timescale 1ns / 1ps

module vwpbp_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input vwpbp_pkg::rsp_payload_type rsp_payload
);
   import vwpbp_pkg::*;

   // a held byte stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp byte changed under stall");

   // bytes of one request come without a gap
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_payload.last_byte |=> rsp_valid)
      else $error("rsp gap inside a request");

   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_reset_req: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("req stalled after reset");

   // keeps req_valid in the port list for waveform context
   logic req_seen;
   assign req_seen = req_valid;
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      !req_seen && !req_stall |=> !req_stall || rsp_valid)
      else $error("req stall with nothing held");

endmodule

bind variable_width_pair_bit_packer_core vwpbp_checker u_vwpbp_checker (.*);
